// ===== rtl/session_keepalive_supervisor_unit_defines.svh =====
// Assertion macros shared by the session keep-alive supervisor RTL.
`ifndef SESSION_KEEPALIVE_SUPERVISOR_UNIT_DEFINES_SVH
`define SESSION_KEEPALIVE_SUPERVISOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define SKS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define SKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sks_pkg.sv =====
// Types and constants of the session keep-alive supervisor.
package sks_pkg;

  localparam int unsigned ReqTypeW  = 3;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned PortW     = 16;
  localparam int unsigned SerialW   = 64;
  localparam int unsigned CmdW      = 32;
  localparam int unsigned KindW     = 2;
  localparam int unsigned DropW     = 2;
  localparam int unsigned CntW      = 4;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CntW-1:0] HelloAcceptAttempts    = CntW'(5);
  localparam logic [CntW-1:0] KeepAliveCheckAttempts = CntW'(5);

  typedef enum logic [ReqTypeW-1:0] {
    REQ_TICK       = 3'd0,
    REQ_CONNECT    = 3'd1,
    REQ_KEEP_ALIVE = 3'd2,
    REQ_COMMAND    = 3'd3,
    REQ_BYE        = 3'd4,
    REQ_UNKNOWN    = 3'd5,
    REQ_RELEASE    = 3'd6
  } req_type_e;

  typedef enum logic [KindW-1:0] {
    SEND_NONE             = 2'd0,
    SEND_CONNECT_ACCEPTED = 2'd1,
    SEND_CONNECT_REFUSED  = 2'd2,
    SEND_KEEP_ALIVE_ACK   = 2'd3
  } send_kind_e;

  typedef enum logic [DropW-1:0] {
    DROP_NONE        = 2'd0,
    DROP_WRONG_PEER  = 2'd1,
    DROP_LATE_KA     = 2'd2,
    DROP_UNKNOWN_MSG = 2'd3
  } drop_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEPT_ATTEMPTS = 1'b0,
    CFG_KEEPALIVE_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SESS_READY    = 2'b01,
    SESS_RESERVED = 2'b10
  } sess_state_e;

endpackage

// ===== rtl/sks_in_if.sv =====
// Request and result channel interfaces of the session keep-alive supervisor.
interface sks_in_if import sks_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [AddrW-1:0]    sender_addr;
  logic [PortW-1:0]    sender_port;
  logic [SerialW-1:0]  msg_serial;
  logic [CmdW-1:0]     command_word;

  modport source (output valid, req_type, sender_addr, sender_port, msg_serial,
                  command_word, input ready);
  modport sink   (input valid, req_type, sender_addr, sender_port, msg_serial,
                  command_word, output ready);
endinterface

interface sks_out_if import sks_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   send_kind;
  logic [AddrW-1:0]   dest_addr;
  logic [PortW-1:0]   dest_port;
  logic [SerialW-1:0] ack_serial;
  logic               cmd_valid;
  logic [CmdW-1:0]    cmd_out;
  logic               state_changed;
  logic               session_state;
  logic [DropW-1:0]   drop_code;

  modport source (output valid, send_kind, dest_addr, dest_port, ack_serial, cmd_valid,
                  cmd_out, state_changed, session_state, drop_code, input ready);
  modport sink   (input valid, send_kind, dest_addr, dest_port, ack_serial, cmd_valid,
                  cmd_out, state_changed, session_state, drop_code, output ready);
endinterface

// ===== rtl/session_keepalive_supervisor_unit.sv =====
// Top level of the single-peer session keep-alive supervisor.
// Usage:
//   req_i carries one message or tick per transfer (valid/ready). rsp_o
//   returns exactly one result per request, in order, also valid/ready.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write accept_attempts (index 0) and
//   keepalive_limit (index 1); write them only while the block is idle.
//   Values take effect at a connect; keepalive_limit also at a keep-alive ack.
// Result timing and throughput:
//   A request transferred at an edge shows its result on rsp_o from the
//   result register in the next cycle. The session and result registers
//   update together: one request per cycle while rsp_o.ready is high.
// Stall:
//   The result register holds while rsp_o.ready is low; req_i.ready is high
//   when the result register is empty or is being drained in the same cycle,
//   so a full register under stall back-pressures the request side.
// Reset:
//   rst_ni clears the session to ready, peer and serial to zero, both
//   counters and registers to 5, and empties the result register.
`include "session_keepalive_supervisor_unit_defines.svh"

module session_keepalive_supervisor_unit import sks_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CntW-1:0]    cfg_wdata_i,
  sks_in_if.sink             req_i,
  sks_out_if.source          rsp_o
);

  // Configuration registers
  logic [CntW-1:0] accept_attempts_q, keepalive_limit_q;

  // Session state
  sess_state_e        state_q, state_d;
  logic [AddrW-1:0]   peer_addr_q, peer_addr_d;
  logic [PortW-1:0]   peer_port_q, peer_port_d;
  logic [SerialW-1:0] last_serial_q, last_serial_d;
  logic [CntW-1:0]    accept_left_q, accept_left_d;
  logic [CntW-1:0]    watchdog_left_q, watchdog_left_d;
  logic               resend_on_q, resend_on_d;

  // Result register
  logic               out_valid_q;
  logic [KindW-1:0]   kind_q, kind_d;
  logic [AddrW-1:0]   daddr_q, daddr_d;
  logic [PortW-1:0]   dport_q, dport_d;
  logic [SerialW-1:0] ack_q, ack_d;
  logic               cvalid_q, cvalid_d;
  logic [CmdW-1:0]    cout_q, cout_d;
  logic               changed_q, changed_d;
  logic               sstate_q;
  logic [DropW-1:0]   drop_q, drop_d;

  logic in_fire, reserved, match;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign in_fire     = req_i.valid && req_i.ready;
  assign reserved    = (state_q == SESS_RESERVED);
  assign match       = reserved && (peer_addr_q == req_i.sender_addr)
                       && (peer_port_q == req_i.sender_port);

  always_comb begin
    logic still_rsv;
    still_rsv       = reserved;
    state_d         = state_q;
    peer_addr_d     = peer_addr_q;
    peer_port_d     = peer_port_q;
    last_serial_d   = last_serial_q;
    accept_left_d   = accept_left_q;
    watchdog_left_d = watchdog_left_q;
    resend_on_d     = resend_on_q;
    kind_d          = SEND_NONE;
    daddr_d         = '0;
    dport_d         = '0;
    ack_d           = '0;
    cvalid_d        = 1'b0;
    cout_d          = '0;
    drop_d          = DROP_NONE;

    unique case (req_i.req_type)
      REQ_TICK: begin
        if (reserved && resend_on_q) begin
          if (accept_left_q <= CntW'(1)) begin
            // attempts exhausted: give up the session
            accept_left_d = '0;
            state_d       = SESS_READY;
            resend_on_d   = 1'b0;
            peer_addr_d   = '0;
            peer_port_d   = '0;
            still_rsv     = 1'b0;
          end else begin
            accept_left_d = accept_left_q - CntW'(1);
            kind_d        = SEND_CONNECT_ACCEPTED;
            daddr_d       = peer_addr_q;
            dport_d       = peer_port_q;
          end
        end
        if (still_rsv) begin
          if (watchdog_left_q == '0) begin
            state_d     = SESS_READY;
            resend_on_d = 1'b0;
            peer_addr_d = '0;
            peer_port_d = '0;
          end else begin
            watchdog_left_d = watchdog_left_q - CntW'(1);
          end
        end
      end
      REQ_CONNECT: begin
        if (!reserved) begin
          last_serial_d   = req_i.msg_serial;
          watchdog_left_d = keepalive_limit_q;
          if (accept_attempts_q <= CntW'(1)) begin
            // session stays ready, peer cleared; serial and watchdog still load
            accept_left_d = '0;
            peer_addr_d   = '0;
            peer_port_d   = '0;
          end else begin
            state_d       = SESS_RESERVED;
            peer_addr_d   = req_i.sender_addr;
            peer_port_d   = req_i.sender_port;
            resend_on_d   = 1'b1;
            accept_left_d = accept_attempts_q - CntW'(1);
            kind_d        = SEND_CONNECT_ACCEPTED;
            daddr_d       = req_i.sender_addr;
            dport_d       = req_i.sender_port;
          end
        end else begin
          kind_d  = SEND_CONNECT_REFUSED;
          daddr_d = req_i.sender_addr;
          dport_d = req_i.sender_port;
          drop_d  = DROP_WRONG_PEER;
        end
      end
      REQ_KEEP_ALIVE: begin
        if (!match) begin
          drop_d = DROP_WRONG_PEER;
        end else if (req_i.msg_serial > last_serial_q) begin
          resend_on_d     = 1'b0;
          watchdog_left_d = keepalive_limit_q;
          kind_d          = SEND_KEEP_ALIVE_ACK;
          daddr_d         = peer_addr_q;
          dport_d         = peer_port_q;
          ack_d           = req_i.msg_serial;
          last_serial_d   = req_i.msg_serial;
        end else begin
          drop_d = DROP_LATE_KA;
        end
      end
      REQ_COMMAND: begin
        if (match) begin
          cvalid_d = 1'b1;
          cout_d   = req_i.command_word;
        end else begin
          drop_d = DROP_WRONG_PEER;
        end
      end
      REQ_BYE: begin
        if (match) begin
          state_d     = SESS_READY;
          resend_on_d = 1'b0;
          peer_addr_d = '0;
          peer_port_d = '0;
        end else begin
          drop_d = DROP_WRONG_PEER;
        end
      end
      REQ_RELEASE: begin
        if (reserved) begin
          state_d     = SESS_READY;
          resend_on_d = 1'b0;
          peer_addr_d = '0;
          peer_port_d = '0;
        end
      end
      default: begin
        drop_d = DROP_UNKNOWN_MSG;
      end
    endcase

    changed_d = (state_d != state_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_attempts_q <= HelloAcceptAttempts;
      keepalive_limit_q <= KeepAliveCheckAttempts;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACCEPT_ATTEMPTS: accept_attempts_q <= cfg_wdata_i;
        CFG_KEEPALIVE_LIMIT: keepalive_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= SESS_READY;
      peer_addr_q     <= '0;
      peer_port_q     <= '0;
      last_serial_q   <= '0;
      accept_left_q   <= HelloAcceptAttempts;
      watchdog_left_q <= KeepAliveCheckAttempts;
      resend_on_q     <= 1'b0;
    end else if (in_fire) begin
      state_q         <= state_d;
      peer_addr_q     <= peer_addr_d;
      peer_port_q     <= peer_port_d;
      last_serial_q   <= last_serial_d;
      accept_left_q   <= accept_left_d;
      watchdog_left_q <= watchdog_left_d;
      resend_on_q     <= resend_on_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the result on every transfer; hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q    <= kind_d;
      daddr_q   <= daddr_d;
      dport_q   <= dport_d;
      ack_q     <= ack_d;
      cvalid_q  <= cvalid_d;
      cout_q    <= cout_d;
      changed_q <= changed_d;
      sstate_q  <= (state_d == SESS_RESERVED);
      drop_q    <= drop_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.send_kind     = kind_q;
  assign rsp_o.dest_addr     = daddr_q;
  assign rsp_o.dest_port     = dport_q;
  assign rsp_o.ack_serial    = ack_q;
  assign rsp_o.cmd_valid     = cvalid_q;
  assign rsp_o.cmd_out       = cout_q;
  assign rsp_o.state_changed = changed_q;
  assign rsp_o.session_state = sstate_q;
  assign rsp_o.drop_code     = drop_q;

  `SKS_ASSERT_NEXT(a_result_follows_transfer, in_fire, out_valid_q, "no result after transfer")
  `SKS_ASSERT_NOW(a_ready_no_resend, !reserved, !resend_on_q, "resend armed while ready")
  `SKS_ASSERT_NOW(a_ack_not_dropped, out_valid_q && (kind_q == SEND_KEEP_ALIVE_ACK),
                  (drop_q == DROP_NONE) && sstate_q, "keep-alive ack with drop or ready")
  `SKS_ASSERT_NEXT(a_session_matches_result, in_fire, sstate_q == reserved,
                   "result state differs from session state")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench of the session keep-alive supervisor: directed table, then random.
module testbench;
  import sks_pkg::*;

  localparam int unsigned LONG_HOLD_CYCLES = 60;
  localparam int unsigned N_DIRECTED       = 27;
  localparam int unsigned N_PHASES         = 6;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [AddrW-1:0]    addr;
    logic [PortW-1:0]    port;
    logic [SerialW-1:0]  serial;
    logic [CmdW-1:0]     cmd;
  } sks_req_t;

  typedef struct packed {
    send_kind_e         send_kind;
    logic [AddrW-1:0]   dest_addr;
    logic [PortW-1:0]   dest_port;
    logic [SerialW-1:0] ack_serial;
    logic               cmd_valid;
    logic [CmdW-1:0]    cmd_out;
    logic               state_changed;
    logic               session_state;
    drop_code_e         drop_code;
  } sks_rsp_t;

  typedef struct {
    sks_req_t req;
    bit       fixed;
    sks_rsp_t rsp;
  } dir_row_t;

  typedef struct {
    logic [CntW-1:0] accept_attempts;
    logic [CntW-1:0] keepalive_limit;
    int unsigned     send_idle;
    int unsigned     recv_stall;
    int unsigned     n_items;
    bit              long_hold;
    bit              mid_drain;
    bit              rand_cfg;
  } phase_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_ACCEPT_ATTEMPTS;
  logic [CntW-1:0]    cfg_wdata_i = '0;

  sks_in_if  req_if ();
  sks_out_if rsp_if ();

  session_keepalive_supervisor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Session shadow and register copies
  logic               sess_reserved = 1'b0;
  logic [AddrW-1:0]   sess_peer_addr = '0;
  logic [PortW-1:0]   sess_peer_port = '0;
  logic [SerialW-1:0] seen_serial = '0;
  logic [CntW-1:0]    accept_left = HelloAcceptAttempts;
  logic [CntW-1:0]    watchdog_left = KeepAliveCheckAttempts;
  logic               resend_on = 1'b0;
  logic [CntW-1:0]    cfg_accept_attempts = HelloAcceptAttempts;
  logic [CntW-1:0]    cfg_keepalive_limit = KeepAliveCheckAttempts;

  sks_rsp_t    pending_rsp_q[$];
  sks_rsp_t    head_rsp;
  int unsigned err_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_seq = 0;
  int unsigned stall_seen = 0;
  int unsigned hold_left = 0;

  logic [AddrW-1:0] pool_addr [4] = '{32'h0A00_0001, 32'hC0A8_0102, 32'h0000_0000, 32'hFFFF_FFFF};
  logic [PortW-1:0] pool_port [4] = '{16'h1F90, 16'h0050, 16'h0000, 16'hFFFF};

  dir_row_t dir_tab [N_DIRECTED];
  phase_t   phase_tab [N_PHASES];

  function automatic void drop_session();
    sess_reserved  = 1'b0;
    resend_on      = 1'b0;
    sess_peer_addr = '0;
    sess_peer_port = '0;
  endfunction

  // Spend one accept attempt; give up the session when none is left
  function automatic bit spend_accept();
    if (accept_left <= CntW'(1)) begin
      accept_left = '0;
      drop_session();
      return 1'b0;
    end
    accept_left = accept_left - 1'b1;
    return 1'b1;
  endfunction

  function automatic sks_rsp_t supervise_step(input sks_req_t r);
    sks_rsp_t o;
    logic     was_reserved;
    logic     peer_hit;
    o            = '0;
    was_reserved = sess_reserved;
    peer_hit     = sess_reserved && sess_peer_addr == r.addr && sess_peer_port == r.port;
    case (r.req_type)
      REQ_TICK: begin
        if (sess_reserved && resend_on && spend_accept()) begin
          o.send_kind = SEND_CONNECT_ACCEPTED;
          o.dest_addr = sess_peer_addr;
          o.dest_port = sess_peer_port;
        end
        if (sess_reserved) begin
          if (watchdog_left == '0) drop_session();
          else watchdog_left = watchdog_left - 1'b1;
        end
      end
      REQ_CONNECT: begin
        if (!sess_reserved) begin
          sess_peer_addr = r.addr;
          sess_peer_port = r.port;
          sess_reserved  = 1'b1;
          seen_serial    = r.serial;
          accept_left    = cfg_accept_attempts;
          watchdog_left  = cfg_keepalive_limit;
          resend_on      = 1'b1;
          if (spend_accept()) begin
            o.send_kind = SEND_CONNECT_ACCEPTED;
            o.dest_addr = r.addr;
            o.dest_port = r.port;
          end
        end else begin
          o.send_kind = SEND_CONNECT_REFUSED;
          o.dest_addr = r.addr;
          o.dest_port = r.port;
          o.drop_code = DROP_WRONG_PEER;
        end
      end
      REQ_KEEP_ALIVE: begin
        if (!peer_hit) o.drop_code = DROP_WRONG_PEER;
        else if (r.serial <= seen_serial) o.drop_code = DROP_LATE_KA;
        else begin
          resend_on    = 1'b0;
          watchdog_left = cfg_keepalive_limit;
          o.send_kind  = SEND_KEEP_ALIVE_ACK;
          o.dest_addr  = sess_peer_addr;
          o.dest_port  = sess_peer_port;
          o.ack_serial = r.serial;
          seen_serial  = r.serial;
        end
      end
      REQ_COMMAND: begin
        if (peer_hit) begin
          o.cmd_valid = 1'b1;
          o.cmd_out   = r.cmd;
        end else o.drop_code = DROP_WRONG_PEER;
      end
      REQ_BYE: begin
        if (peer_hit) drop_session();
        else o.drop_code = DROP_WRONG_PEER;
      end
      REQ_RELEASE: begin
        if (sess_reserved) drop_session();
      end
      default: o.drop_code = DROP_UNKNOWN_MSG;
    endcase
    o.state_changed = was_reserved != sess_reserved;
    o.session_state = sess_reserved;
    return o;
  endfunction

  function automatic sks_req_t mk_req(input logic [ReqTypeW-1:0] t, input logic [AddrW-1:0] a,
                                      input logic [PortW-1:0] p, input logic [SerialW-1:0] s,
                                      input logic [CmdW-1:0] c);
    sks_req_t r;
    r = '{req_type: t, addr: a, port: p, serial: s, cmd: c};
    return r;
  endfunction

  function automatic sks_rsp_t mk_rsp(input send_kind_e k, input logic [AddrW-1:0] a,
                                      input logic [PortW-1:0] p, input logic [SerialW-1:0] ack,
                                      input logic cv, input logic [CmdW-1:0] c, input logic chg,
                                      input logic st, input drop_code_e d);
    sks_rsp_t o;
    o = '{send_kind: k, dest_addr: a, dest_port: p, ack_serial: ack, cmd_valid: cv,
          cmd_out: c, state_changed: chg, session_state: st, drop_code: d};
    return o;
  endfunction

  // Mostly traffic from the current peer with rising serials, plus strangers and junk
  function automatic sks_req_t pick_request();
    sks_req_t    r;
    int unsigned roll;
    logic [1:0]  k;
    roll = $urandom_range(0, 99);
    if (!sess_reserved) begin
      if (roll < 45) r.req_type = REQ_CONNECT;
      else if (roll < 70) r.req_type = REQ_TICK;
      else r.req_type = ReqTypeW'($urandom_range(0, 7));
    end else begin
      if (roll < 30) r.req_type = REQ_TICK;
      else if (roll < 58) r.req_type = REQ_KEEP_ALIVE;
      else if (roll < 70) r.req_type = REQ_COMMAND;
      else if (roll < 78) r.req_type = REQ_CONNECT;
      else if (roll < 84) r.req_type = REQ_BYE;
      else if (roll < 88) r.req_type = REQ_RELEASE;
      else if (roll < 92) r.req_type = REQ_UNKNOWN;
      else r.req_type = ReqTypeW'($urandom_range(0, 7));
    end
    k = 2'($urandom_range(0, 3));
    if (sess_reserved && $urandom_range(0, 99) < 80) begin
      r.addr = sess_peer_addr;
      r.port = sess_peer_port;
    end else if ($urandom_range(0, 1) == 0) begin
      r.addr = pool_addr[k];
      r.port = pool_port[k];
    end else begin
      r.addr = $urandom;
      r.port = PortW'($urandom);
    end
    roll = $urandom_range(0, 99);
    if (r.req_type == REQ_KEEP_ALIVE && roll < 70)
      r.serial = seen_serial + SerialW'($urandom_range(1, 4));
    else if (r.req_type == REQ_KEEP_ALIVE && roll < 85)
      r.serial = seen_serial - SerialW'($urandom_range(0, 2));
    else if (r.req_type == REQ_CONNECT && roll < 50)
      r.serial = SerialW'($urandom_range(0, 1000));
    else
      r.serial = {$urandom, $urandom};
    r.cmd = $urandom;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    err_cnt++;
    $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, exp_v, got_v);
  endtask

  task automatic check_rsp(input sks_rsp_t e);
    if (rsp_if.send_kind !== e.send_kind)
      flag_mismatch("send_kind", 64'(e.send_kind), 64'(rsp_if.send_kind));
    if (rsp_if.dest_addr !== e.dest_addr)
      flag_mismatch("dest_addr", 64'(e.dest_addr), 64'(rsp_if.dest_addr));
    if (rsp_if.dest_port !== e.dest_port)
      flag_mismatch("dest_port", 64'(e.dest_port), 64'(rsp_if.dest_port));
    if (rsp_if.ack_serial !== e.ack_serial)
      flag_mismatch("ack_serial", e.ack_serial, rsp_if.ack_serial);
    if (rsp_if.cmd_valid !== e.cmd_valid)
      flag_mismatch("cmd_valid", 64'(e.cmd_valid), 64'(rsp_if.cmd_valid));
    if (rsp_if.cmd_out !== e.cmd_out)
      flag_mismatch("cmd_out", 64'(e.cmd_out), 64'(rsp_if.cmd_out));
    if (rsp_if.state_changed !== e.state_changed)
      flag_mismatch("state_changed", 64'(e.state_changed), 64'(rsp_if.state_changed));
    if (rsp_if.session_state !== e.session_state)
      flag_mismatch("session_state", 64'(e.session_state), 64'(rsp_if.session_state));
    if (rsp_if.drop_code !== e.drop_code)
      flag_mismatch("drop_code", 64'(e.drop_code), 64'(rsp_if.drop_code));
  endtask

  // Offer one request; predict it once the transfer happens
  task automatic send_req(input sks_req_t r, input bit fixed, input sks_rsp_t fixed_rsp);
    sks_rsp_t p;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= r.req_type;
    req_if.sender_addr  <= r.addr;
    req_if.sender_port  <= r.port;
    req_if.msg_serial   <= r.serial;
    req_if.command_word <= r.cmd;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    p = supervise_step(r);
    pending_rsp_q.push_back(fixed ? fixed_rsp : p);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_cfgs(input logic [CntW-1:0] acc, input logic [CntW-1:0] ka);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ACCEPT_ATTEMPTS;
    cfg_wdata_i <= acc;
    @(posedge clk_i);
    cfg_accept_attempts = acc;
    cfg_idx_i   <= CFG_KEEPALIVE_LIMIT;
    cfg_wdata_i <= ka;
    @(posedge clk_i);
    cfg_keepalive_limit = ka;
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_seq != stall_seen) begin
      stall_seen    <= stall_seq;
      hold_left     <= LONG_HOLD_CYCLES;
      rsp_if.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_if.ready  <= 1'b0;
    end else begin
      rsp_if.ready  <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, 64'(rsp_if.send_kind));
      end else begin
        head_rsp = pending_rsp_q.pop_front();
        check_rsp(head_rsp);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned ph;
    int unsigned k;
    logic [CntW-1:0] acc;
    logic [CntW-1:0] ka;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_TICK;
    req_if.sender_addr  = '0;
    req_if.sender_port  = '0;
    req_if.msg_serial   = '0;
    req_if.command_word = '0;
    rsp_if.ready        = 1'b0;

    dir_tab = '{
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b1,
        mk_rsp(SEND_NONE, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0, DROP_NONE)},
      '{mk_req(REQ_BYE, '0, '0, '0, '0), 1'b1,
        mk_rsp(SEND_NONE, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0, DROP_WRONG_PEER)},
      '{mk_req(REQ_RELEASE, '0, '0, '0, '0), 1'b1,
        mk_rsp(SEND_NONE, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0, DROP_NONE)},
      '{mk_req(REQ_UNKNOWN, '1, '1, '1, '1), 1'b1,
        mk_rsp(SEND_NONE, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0, DROP_UNKNOWN_MSG)},
      '{mk_req(3'd7, '0, '0, '0, '0), 1'b1,
        mk_rsp(SEND_NONE, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0, DROP_UNKNOWN_MSG)},
      '{mk_req(REQ_KEEP_ALIVE, '1, '1, 64'd1, '0), 1'b1,
        mk_rsp(SEND_NONE, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0, DROP_WRONG_PEER)},
      '{mk_req(REQ_COMMAND, '1, '1, '0, '1), 1'b1,
        mk_rsp(SEND_NONE, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0, DROP_WRONG_PEER)},
      '{mk_req(REQ_CONNECT, '1, '1, '0, '0), 1'b1,
        mk_rsp(SEND_CONNECT_ACCEPTED, '1, '1, '0, 1'b0, '0, 1'b1, 1'b1, DROP_NONE)},
      '{mk_req(REQ_CONNECT, '0, '0, '0, '0), 1'b1,
        mk_rsp(SEND_CONNECT_REFUSED, '0, '0, '0, 1'b0, '0, 1'b0, 1'b1, DROP_WRONG_PEER)},
      '{mk_req(REQ_KEEP_ALIVE, '1, '1, '0, '0), 1'b1,
        mk_rsp(SEND_NONE, '0, '0, '0, 1'b0, '0, 1'b0, 1'b1, DROP_LATE_KA)},
      '{mk_req(REQ_KEEP_ALIVE, '1, '0, 64'd1, '0), 1'b1,
        mk_rsp(SEND_NONE, '0, '0, '0, 1'b0, '0, 1'b0, 1'b1, DROP_WRONG_PEER)},
      '{mk_req(REQ_KEEP_ALIVE, '1, '1, 64'd1, '0), 1'b1,
        mk_rsp(SEND_KEEP_ALIVE_ACK, '1, '1, 64'd1, 1'b0, '0, 1'b0, 1'b1, DROP_NONE)},
      '{mk_req(REQ_COMMAND, '1, '1, '0, '1), 1'b1,
        mk_rsp(SEND_NONE, '0, '0, '0, 1'b1, '1, 1'b0, 1'b1, DROP_NONE)},
      // watchdog runs down without keep-alives
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b0, '0},
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b0, '0},
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b0, '0},
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b0, '0},
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b0, '0},
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b0, '0},
      '{mk_req(REQ_CONNECT, 32'h0A00_0001, 16'h1F90, '1, '0), 1'b0, '0},
      '{mk_req(REQ_KEEP_ALIVE, 32'h0A00_0001, 16'h1F90, '1, '0), 1'b0, '0},
      // accept resends run out
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b0, '0},
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b0, '0},
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b0, '0},
      '{mk_req(REQ_TICK, '0, '0, '0, '0), 1'b0, '0},
      '{mk_req(REQ_CONNECT, 32'h0A00_0001, 16'h1F90, 64'd5, '0), 1'b0, '0},
      '{mk_req(REQ_BYE, 32'h0A00_0001, 16'h1F90, '0, '0), 1'b0, '0}
    };

    phase_tab = '{
      '{4'd2,  4'd1,  0,  0,  150, 1'b0, 1'b0, 1'b0},
      '{4'd15, 4'd15, 45, 0,  150, 1'b0, 1'b1, 1'b0},
      '{4'd1,  4'd0,  0,  45, 150, 1'b0, 1'b0, 1'b0},
      '{4'd0,  4'd3,  17, 17, 150, 1'b0, 1'b0, 1'b0},
      '{4'd5,  4'd5,  0,  0,  150, 1'b1, 1'b0, 1'b1},
      '{4'd5,  4'd5,  17, 17, 150, 1'b0, 1'b0, 1'b1}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < N_DIRECTED; k++)
      send_req(dir_tab[k].req, dir_tab[k].fixed, dir_tab[k].rsp);

    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      acc = phase_tab[ph].accept_attempts;
      ka  = phase_tab[ph].keepalive_limit;
      if (phase_tab[ph].rand_cfg) begin
        acc = CntW'($urandom_range(0, 15));
        ka  = CntW'($urandom_range(0, 15));
      end
      write_cfgs(acc, ka);
      send_idle_pct = phase_tab[ph].send_idle;
      recv_stall_pct <= phase_tab[ph].recv_stall;
      for (k = 0; k < phase_tab[ph].n_items; k++) begin
        // hold the result side off while requests keep coming
        if (phase_tab[ph].long_hold && k == 40) stall_seq <= stall_seq + 1;
        // pause the request side until everything is back
        if (phase_tab[ph].mid_drain && k == phase_tab[ph].n_items / 2) wait_idle();
        send_req(pick_request(), 1'b0, '0);
      end
    end

    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (err_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== session_keepalive_supervisor_unit.f =====
+incdir+rtl
rtl/sks_pkg.sv
rtl/sks_in_if.sv
rtl/session_keepalive_supervisor_unit.sv
verif/testbench.sv
